### rtl/fdvr_pkg.sv
// ----------------------------------------------------------------------------
// fdvr_pkg
// Shared widths and header field positions for the flit deserializer.
// ----------------------------------------------------------------------------
package fdvr_pkg;

  localparam int WORD_W     = 16;
  localparam int SLICES     = 8;
  localparam int SLICE_W    = $clog2(SLICES);
  localparam int HALF_W     = 64;
  localparam int VAULT_COUNT = 8;
  localparam int VAULT_W    = $clog2(VAULT_COUNT);
  localparam int QUAD_W     = 2;
  localparam int LEN_W      = 5;
  localparam int BSC_W      = 2;

  // header fields, in flit bit positions
  localparam int ADDR_LSB   = 24;
  localparam int LEN_LSB    = 7;
  localparam int VAULT_BASE = 5;
  localparam int QUAD_BASE  = 8;
  localparam int VAULT_LSB  = ADDR_LSB + VAULT_BASE;
  localparam int QUAD_LSB   = ADDR_LSB + QUAD_BASE;

endpackage

### rtl/fdvr_ifs.sv
// ----------------------------------------------------------------------------
// fdvr channel interfaces
// Valid/ready channels for link words, flits and the block size register.
// ----------------------------------------------------------------------------
interface fdvr_word_if;
  logic                        valid;
  logic                        ready;
  logic [fdvr_pkg::WORD_W-1:0] serial_word;

  modport source (output valid, output serial_word, input ready);
  modport sink   (input valid, input serial_word, output ready);
endinterface

interface fdvr_flit_if;
  logic                         valid;
  logic                         ready;
  logic [fdvr_pkg::HALF_W-1:0]  flit_low;
  logic [fdvr_pkg::HALF_W-1:0]  flit_high;
  logic [fdvr_pkg::VAULT_W-1:0] target_vault;
  logic [fdvr_pkg::QUAD_W-1:0]  target_quadrant;
  logic                         last_flit;

  modport source (output valid, output flit_low, output flit_high, output target_vault,
                  output target_quadrant, output last_flit, input ready);
  modport sink   (input valid, input flit_low, input flit_high, input target_vault,
                  input target_quadrant, input last_flit, output ready);
endinterface

interface fdvr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fdvr_pkg::BSC_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/flit_deserializer_vault_router_core.sv
// ----------------------------------------------------------------------------
// flit_deserializer_vault_router_core
// Packs eight link words into a flit and tags it with the packet's route.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        transfer when
//  link     in   serial_word[15:0]                              valid & ready
//  flit     out  flit_low, flit_high, target_vault/quadrant,    valid & ready
//                last_flit
//  cfg      in   data[1:0] = block size code                    valid & ready
//
// one link word per cycle; the edge that takes every eighth word also loads
// the flit into the output register, so the flit is offered in the next cycle.
// link.ready drops only while a flit waits in the output register and
// flit.ready is low. cfg is always ready.
// rst is synchronous: slice count, route, length and valid clear; the
// block size code returns to 0 (32 bytes).
// ----------------------------------------------------------------------------
module flit_deserializer_vault_router_core (
  input  logic        clk,
  input  logic        rst,
  fdvr_word_if.sink   link,
  fdvr_flit_if.source flit,
  fdvr_cfg_if.sink    cfg
);

  logic [fdvr_pkg::BSC_W-1:0]   block_size_code;
  logic [fdvr_pkg::SLICE_W-1:0] slice_index;
  logic [fdvr_pkg::WORD_W-1:0]  partial_flit [fdvr_pkg::SLICES-1];
  logic [fdvr_pkg::LEN_W-1:0]   flits_remaining;
  logic [fdvr_pkg::LEN_W-1:0]   flits_remaining_next;
  logic [fdvr_pkg::VAULT_W-1:0] packet_vault;
  logic [fdvr_pkg::VAULT_W-1:0] packet_vault_next;
  logic [fdvr_pkg::QUAD_W-1:0]  packet_quadrant;
  logic [fdvr_pkg::QUAD_W-1:0]  packet_quadrant_next;
  logic                         out_valid;

  logic                         link_xfer;
  logic                         flit_done;
  logic [fdvr_pkg::HALF_W-1:0]  lo;
  logic [fdvr_pkg::HALF_W-1:0]  hi;
  logic [fdvr_pkg::LEN_W-1:0]   hdr_len;

  assign cfg.ready  = 1'b1;
  assign link.ready = !out_valid || flit.ready;
  assign link_xfer  = link.valid && link.ready;
  assign flit_done  = link_xfer && (slice_index == fdvr_pkg::SLICE_W'(fdvr_pkg::SLICES - 1));

  assign lo = {partial_flit[3], partial_flit[2], partial_flit[1], partial_flit[0]};
  assign hi = {link.serial_word, partial_flit[6], partial_flit[5], partial_flit[4]};
  assign hdr_len = lo[fdvr_pkg::LEN_LSB +: fdvr_pkg::LEN_W];

  always_comb begin
    packet_vault_next    = packet_vault;
    packet_quadrant_next = packet_quadrant;
    if (flits_remaining == '0) begin
      // header: route at an offset set by the block size code
      packet_vault_next    = lo[(fdvr_pkg::VAULT_LSB + int'(block_size_code)) +: fdvr_pkg::VAULT_W];
      packet_quadrant_next = lo[(fdvr_pkg::QUAD_LSB + int'(block_size_code)) +: fdvr_pkg::QUAD_W];
      // zero length counts as a single flit
      flits_remaining_next = (hdr_len == '0) ? '0 : hdr_len - fdvr_pkg::LEN_W'(1);
    end else begin
      flits_remaining_next = flits_remaining - fdvr_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_code <= '0;
      slice_index     <= '0;
      flits_remaining <= '0;
      packet_vault    <= '0;
      packet_quadrant <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        block_size_code <= cfg.data;
      end
      if (link_xfer) begin
        slice_index <= slice_index + fdvr_pkg::SLICE_W'(1);
      end
      if (flit_done) begin
        flits_remaining <= flits_remaining_next;
        packet_vault    <= packet_vault_next;
        packet_quadrant <= packet_quadrant_next;
        out_valid       <= 1'b1;
      end else if (flit.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_xfer && !flit_done) begin
      partial_flit[slice_index] <= link.serial_word;
    end
    if (flit_done) begin
      flit.flit_low        <= lo;
      flit.flit_high       <= hi;
      flit.target_vault    <= packet_vault_next;
      flit.target_quadrant <= packet_quadrant_next;
      flit.last_flit       <= (flits_remaining_next == '0);
    end
  end

  assign flit.valid = out_valid;

endmodule
